### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wrpt_pkg.sv
// ----------------------------------------------------------------------------
// wrpt_pkg
// Field widths, codes and shared types of the weighted pick table.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpt_pkg;

    localparam int WEIGHT_W = 8;
    localparam int DRAW_W   = 14;
    localparam int TOTAL_W  = 14;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'h3FFF;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_APPENDED = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_PICKED   = 2'd2;
    localparam t_status ST_NOPICK   = 2'd3;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_PICK   = 1'b1;

    // Register word index on the configuration port.
    localparam logic REG_REDUCE_MODE = 1'b0;

    typedef struct packed {
        logic               busy;
        logic [TOTAL_W-1:0] total;
    } t_seq_stat;

endpackage

`default_nettype wire

### src/wrpt_in_if.sv
// ----------------------------------------------------------------------------
// wrpt_in_if
// Request channel: append a weight or pick an entry by draw.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrpt_in_if;
    import wrpt_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [WEIGHT_W-1:0] weight;
    logic [DRAW_W-1:0]   draw;

    modport source (output valid, output action, output weight, output draw, input ready);
    modport sink   (input valid, input action, input weight, input draw, output ready);
endinterface

`default_nettype wire

### src/wrpt_out_if.sv
// ----------------------------------------------------------------------------
// wrpt_out_if
// Result channel: status and entry index of each request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrpt_out_if;
    import wrpt_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [INDEX_W-1:0] entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

`default_nettype wire

### src/wrpt_ram.sv
// ----------------------------------------------------------------------------
// wrpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/wrpt_seq.sv
// ----------------------------------------------------------------------------
// wrpt_seq
// Request sequencer: appends weights, walks the table one entry per cycle
// through a shared accumulate-and-compare unit, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpt_seq #(
    parameter int MAX_ENTRIES = 64,
    parameter int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_reduce_mode,
    wrpt_in_if.sink                           in_ch,
    wrpt_out_if.source                        out_ch,
    output logic                              o_wr_en,
    output logic [IW-1:0]                     o_wr_addr,
    output logic [wrpt_pkg::WEIGHT_W-1:0]     o_wr_data,
    output logic [IW-1:0]                     o_rd_addr,
    input  wire logic [wrpt_pkg::WEIGHT_W-1:0] i_rd_data,
    output wrpt_pkg::t_seq_stat               o_stat
);
    import wrpt_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [IW-1:0]      r_idx, n_idx;
    logic [TOTAL_W-1:0] r_sum, n_sum;
    logic [DRAW_W-1:0]  r_draw, n_draw;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [INDEX_W-1:0] r_index, n_index;

    logic               accept;
    logic               full;
    logic [TOTAL_W:0]   append_sum;
    logic [TOTAL_W:0]   walk_sum;
    logic               hit;
    logic               last;

    assign in_ch.ready = (r_state == S_IDLE) && (!r_out_valid || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;

    assign append_sum = {1'b0, r_total} + (TOTAL_W + 1)'(in_ch.weight);
    assign full       = (r_count >= CW'(MAX_ENTRIES)) ||
                        (append_sum > {1'b0, TOTAL_MAX});

    // Shared unit: running sum of the entry now on the read port.
    assign walk_sum = {1'b0, r_sum} + (TOTAL_W + 1)'(i_rd_data);
    assign hit      = walk_sum > (TOTAL_W + 1)'(r_draw);
    assign last     = (CW'(r_idx) + CW'(1)) >= r_count;

    // Entry 0 is read while idle so its weight is ready on the first walk cycle.
    assign o_rd_addr = (r_state == S_WALK) ? (r_idx + IW'(1)) : '0;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_draw      = r_draw;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_status    = r_status;
        n_index     = r_index;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_count[IW-1:0];
        o_wr_data   = in_ch.weight;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_ch.action == ACT_APPEND) begin
                        n_out_valid = 1'b1;
                        n_index     = '0;
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en  = 1'b1;
                            n_total  = append_sum[TOTAL_W-1:0];
                            n_count  = r_count + CW'(1);
                            n_status = ST_APPENDED;
                            n_index  = INDEX_W'(r_count[IW-1:0]);
                        end
                    end else if ((r_total == '0) || (in_ch.draw >= r_total)) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NOPICK;
                        n_index     = '0;
                    end else begin
                        n_state = S_WALK;
                        n_idx   = '0;
                        n_sum   = '0;
                        n_draw  = in_ch.draw;
                    end
                end
            end
            S_WALK: begin
                if (hit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_PICKED;
                    n_index     = INDEX_W'(r_idx);
                    if (i_reduce_mode && (i_rd_data > WEIGHT_W'(1))) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_idx;
                        o_wr_data = i_rd_data - WEIGHT_W'(1);
                        n_total   = r_total - TOTAL_W'(1);
                    end
                end else if (last) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_NOPICK;
                    n_index     = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_sum = walk_sum[TOTAL_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_draw   <= n_draw;
        r_status <= n_status;
        r_index  <= n_index;
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.status      = r_status;
    assign out_ch.entry_index = r_index;

    assign o_stat.busy  = (r_state == S_WALK);
    assign o_stat.total = r_total;

endmodule

`default_nettype wire

### src/weighted_random_pick_table.sv
// ----------------------------------------------------------------------------
// weighted_random_pick_table
// Table of entry weights with append and roulette-wheel pick requests.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (action, weight, draw); one result per request
// leaves on out_ch (status, entry_index). Both are valid/ready channels.
// An append, a full table and a draw outside 0..total-1 give their result
// in the cycle after the request beat, and such requests can follow one per
// cycle while out_ch takes each result. A pick walks from entry 0 to the first
// entry whose running weight sum exceeds the draw. The walk reads one stored
// weight per cycle from the single read port of the weight RAM and adds it in
// the one accumulate-and-compare unit. in_ch is not ready during a walk. The
// result sits in an output register; a new request is taken while it waits
// only if out_ch takes the beat in the same cycle, so a stalled receiver
// holds off requests and no result is dropped. reduce_mode is written over the
// APB port at addresses 0..3 by the user only while idle, which the block
// does not enforce. Reset empties the table (count and total to zero) and
// clears reduce_mode; the weight RAM itself is not cleared, only entries
// below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module weighted_random_pick_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wrpt_in_if.sink          in_ch,
    wrpt_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import wrpt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic                r_reduce_mode;
    logic                reg_hit;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic [IW-1:0]       rd_addr;
    logic [WEIGHT_W-1:0] rd_data;
    t_seq_stat           stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_REDUCE_MODE);
    assign prdata  = reg_hit ? {31'b0, r_reduce_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_reduce_mode <= pwdata[0];
        end
    end

    wrpt_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_reduce_mode (r_reduce_mode),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_stat        (stat)
    );

    wrpt_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // A stalled result blocks new requests.
    `ASSERT_CLK(a_stall_blocks_req, i_clk, i_rst_n,
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready,
        "request taken while result stalled")

    // No request is taken during a walk.
    `ASSERT_CLK(a_walk_not_ready, i_clk, i_rst_n,
        stat.busy |-> !in_ch.ready,
        "request taken during table walk")

    // A draw at or above the total answers with no pick on the next cycle.
    `ASSERT_CLK(a_draw_range, i_clk, i_rst_n,
        (in_ch.valid && in_ch.ready && (in_ch.action == ACT_PICK) &&
         (in_ch.draw >= stat.total)) |=> (out_ch.valid && (out_ch.status == ST_NOPICK)),
        "out-of-range draw not rejected")

endmodule

`default_nettype wire
